>>> src/fld_pkg.sv
package fld_pkg;

	// Default longest accepted frame length (length byte value)
	localparam int MAX_LEN_DEF = 64;

	// Register reset values
	localparam logic [7:0]  FLAG_RST    = 8'hFF;
	localparam logic [15:0] TIMEOUT_RST = 16'd50;

	// Configuration port widths and register indexes
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_FLAG    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = CFG_IDX_W'(1);

	// Commands from the controller to the datapath
	typedef struct packed {
		logic in_byte;   // parse the byte taken from the input channel
		logic in_tick;   // apply one time tick
		logic rp_read;   // read the ring at the rescan pointer
		logic rp_proc;   // parse the byte read for rescan
		logic em_read;   // read the ring at the emit pointer
		logic em_load;   // move the emit read data into the output register
	} fld_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic step_emit; // the parsed byte closed a frame with a good end flag
		logic more;      // ring holds bytes that still wait for parsing
		logic em_last;   // emit byte in flight is the last one of the frame
		logic out_free;  // output register can take a byte this cycle
	} fld_sts_t;

endpackage

>>> src/fld_intf.sv
interface fld_in_if;
	logic       valid;
	logic       ready;
	logic       func;
	logic [7:0] data_byte;

	modport source(output valid, output func, output data_byte, input ready);
	modport sink(input valid, input func, input data_byte, output ready);
endinterface

interface fld_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       frame_last;

	modport source(output valid, output frame_byte, output frame_last, input ready);
	modport sink(input valid, input frame_byte, input frame_last, output ready);
endinterface

interface fld_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [fld_pkg::CFG_IDX_W-1:0]  idx;
	logic [fld_pkg::CFG_DATA_W-1:0] wdata;

	modport source(output valid, output idx, output wdata, input ready);
	modport sink(input valid, input idx, input wdata, output ready);
endinterface

>>> src/fld_datapath.sv
module fld_datapath #(
	parameter int MAX_LEN = fld_pkg::MAX_LEN_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  fld_pkg::fld_cmd_t              cmd,
	output fld_pkg::fld_sts_t              sts,
	input  logic [7:0]                     data_byte,
	input  logic                           cfg_valid,
	input  logic [fld_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [fld_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                           out_ready,
	output logic                           out_valid,
	output logic [7:0]                     out_byte,
	output logic                           out_last
);

	// Ring depth exceeds MAX_LEN so a frame and its end byte never wrap onto the length byte
	localparam int PW = $clog2(MAX_LEN + 1);
	localparam int Depth = 1 << PW;
	localparam int CW = $clog2(MAX_LEN + 1);
	localparam logic [7:0] MaxLenB = 8'(MAX_LEN);

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_LEN,
		PH_BODY,
		PH_END
	} phase_t;

	logic [7:0]    mem_q [Depth];
	logic [7:0]    rdata_q;
	logic [PW-1:0] rd_addr;

	logic [PW-1:0] wr_ptr_q, rd_ptr_q, len_pos_q, em_ptr_q;
	logic [PW-1:0] wr_ptr_d, rd_ptr_d, len_pos_d;
	logic [CW-1:0] fill_q, fill_d, fill_inc, em_cnt_q;
	logic [7:0]    frame_length_q, frame_length_d;
	logic [7:0]    flag_q;
	logic [15:0]   timeout_q, idle_q, idle_d, idle_inc, lim;
	phase_t        phase_q, phase_d;
	logic          out_valid_q, out_last_q;
	logic [7:0]    out_byte_q;

	logic          step;
	logic [7:0]    b;
	logic [PW-1:0] pos;
	logic          emit;

	// Parse one byte, or apply one tick
	always_comb begin
		step           = cmd.in_byte || cmd.rp_proc;
		b              = cmd.in_byte ? data_byte : rdata_q;
		pos            = cmd.in_byte ? wr_ptr_q : rd_ptr_q;
		wr_ptr_d       = cmd.in_byte ? wr_ptr_q + 1'b1 : wr_ptr_q;
		rd_ptr_d       = rd_ptr_q;
		len_pos_d      = len_pos_q;
		fill_d         = fill_q;
		fill_inc       = fill_q + 1'b1;
		frame_length_d = frame_length_q;
		phase_d        = phase_q;
		idle_d         = idle_q;
		idle_inc       = (idle_q == 16'hFFFF) ? idle_q : idle_q + 16'd1;
		lim            = (timeout_q == 16'd0) ? 16'd1 : timeout_q;
		emit           = 1'b0;
		if (step) begin
			rd_ptr_d = pos + 1'b1;
			if (cmd.in_byte) begin
				idle_d = 16'd0;
			end
			unique case (phase_q)
				PH_HUNT: begin
					if (b == flag_q) begin
						phase_d = PH_LEN;
						fill_d  = '0;
					end
				end
				PH_LEN: begin
					if (b == 8'd0) begin
						phase_d = PH_HUNT;
					end else if (b == flag_q) begin
						// another start flag: keep waiting for the length
						phase_d = PH_LEN;
					end else if (b > MaxLenB) begin
						phase_d = PH_HUNT;
						fill_d  = '0;
					end else begin
						frame_length_d = b;
						len_pos_d      = pos;
						fill_d         = CW'(1);
						phase_d        = (b == 8'd1) ? PH_END : PH_BODY;
					end
				end
				PH_BODY: begin
					fill_d = fill_inc;
					if (8'(fill_inc) >= frame_length_q) begin
						phase_d = PH_END;
					end
				end
				PH_END: begin
					phase_d = PH_HUNT;
					fill_d  = '0;
					if (b == flag_q) begin
						emit = 1'b1;
					end else begin
						// rescan from the byte after the length byte
						rd_ptr_d = len_pos_q + 1'b1;
					end
				end
			endcase
		end else if (cmd.in_tick && phase_q != PH_HUNT) begin
			if (idle_inc >= lim) begin
				phase_d        = PH_HUNT;
				fill_d         = '0;
				frame_length_d = 8'd0;
				idle_d         = 16'd0;
			end else begin
				idle_d = idle_inc;
			end
		end
	end

	// Hold parser state, pointers, registers and output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q       <= '0;
			rd_ptr_q       <= '0;
			len_pos_q      <= '0;
			fill_q         <= '0;
			frame_length_q <= 8'd0;
			phase_q        <= PH_HUNT;
			idle_q         <= 16'd0;
			flag_q         <= fld_pkg::FLAG_RST;
			timeout_q      <= fld_pkg::TIMEOUT_RST;
			em_cnt_q       <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			wr_ptr_q       <= wr_ptr_d;
			rd_ptr_q       <= rd_ptr_d;
			len_pos_q      <= len_pos_d;
			fill_q         <= fill_d;
			frame_length_q <= frame_length_d;
			phase_q        <= phase_d;
			idle_q         <= idle_d;
			if (cfg_valid) begin
				unique case (cfg_idx)
					fld_pkg::CFG_FLAG:    flag_q    <= cfg_wdata[7:0];
					fld_pkg::CFG_TIMEOUT: timeout_q <= cfg_wdata[15:0];
					default: ;
				endcase
			end
			if (emit) begin
				em_cnt_q <= frame_length_q[CW-1:0];
			end else if (cmd.em_load) begin
				em_cnt_q <= em_cnt_q - 1'b1;
			end
			if (cmd.em_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rd_addr = cmd.em_read ? em_ptr_q : rd_ptr_q;

	// Ring memory, emit pointer and output payload
	always_ff @(posedge clk) begin
		if (cmd.in_byte) begin
			mem_q[wr_ptr_q] <= data_byte;
		end
		if (cmd.rp_read || cmd.em_read) begin
			rdata_q <= mem_q[rd_addr];
		end
		if (emit) begin
			em_ptr_q <= len_pos_q;
		end else if (cmd.em_load) begin
			em_ptr_q <= em_ptr_q + 1'b1;
		end
		if (cmd.em_load) begin
			out_byte_q <= rdata_q;
			out_last_q <= (em_cnt_q == CW'(1));
		end
	end

	assign sts.step_emit = emit;
	assign sts.more      = (rd_ptr_d != wr_ptr_d);
	assign sts.em_last   = (em_cnt_q == CW'(1));
	assign sts.out_free  = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

`ifndef SYNTHESIS
	a_caught_up: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.in_byte || cmd.in_tick) |-> (rd_ptr_q == wr_ptr_q))
		else $error("new item taken while ring bytes wait for parsing");
	a_idle_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_HUNT) |-> (idle_q == 16'd0))
		else $error("idle count running while hunting");
	a_end_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_END) |-> (8'(fill_q) == frame_length_q))
		else $error("end flag awaited with frame not full");
`endif

endmodule

>>> src/fld_ctrl.sv
module fld_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_func,
	output logic              in_ready,
	input  fld_pkg::fld_sts_t sts,
	output fld_pkg::fld_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RP_RD,
		ST_RP_PROC,
		ST_EM_RD,
		ST_EM_OUT
	} state_t;

	state_t state_q, state_d;
	logic   ready_q;
	logic   fire;

	// Decode commands and next state
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		fire    = in_valid && ready_q;
		unique case (state_q)
			ST_IDLE: begin
				if (fire) begin
					cmd.in_byte = !in_func;
					cmd.in_tick = in_func;
					if (!in_func) begin
						if (sts.step_emit) begin
							state_d = ST_EM_RD;
						end else if (sts.more) begin
							state_d = ST_RP_RD;
						end
					end
				end
			end
			ST_RP_RD: begin
				cmd.rp_read = 1'b1;
				state_d     = ST_RP_PROC;
			end
			ST_RP_PROC: begin
				cmd.rp_proc = 1'b1;
				if (sts.step_emit) begin
					state_d = ST_EM_RD;
				end else if (sts.more) begin
					state_d = ST_RP_RD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_EM_RD: begin
				cmd.em_read = 1'b1;
				state_d     = ST_EM_OUT;
			end
			ST_EM_OUT: begin
				if (sts.out_free) begin
					cmd.em_load = 1'b1;
					if (!sts.em_last) begin
						state_d = ST_EM_RD;
					end else if (sts.more) begin
						state_d = ST_RP_RD;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Hold state and the registered input ready
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ready_q <= 1'b1;
		end else begin
			state_q <= state_d;
			ready_q <= (state_d == ST_IDLE);
		end
	end

	assign in_ready = ready_q;

`ifndef SYNTHESIS
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ready_q |-> (state_q == ST_IDLE))
		else $error("input ready outside idle");
	a_emit_start: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.in_byte && sts.step_emit) |=> (state_q == ST_EM_RD))
		else $error("closed frame not emitted");
	a_emit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EM_OUT && !sts.out_free) |=> (state_q == ST_EM_OUT))
		else $error("emit byte dropped while output stalled");
`endif

endmodule

>>> src/flag_length_frame_deframer_unit.sv
// Flag-delimited, length-prefixed deframer. Each input transfer is a received byte
// (func 0) or one time tick (func 1); each output transfer is one byte of a good
// frame, length byte first, with frame_last on its final byte. In the normal flow
// one byte or tick is taken per cycle and parsed on arrival. When an end flag
// matches, input is held off while the frame (L bytes) goes out of the ring buffer,
// each byte read through the single registered read port of the ring and then
// loaded into the output register; a stalled sink stretches this further. When the
// byte after the body is not the flag, the L bytes after the length byte (the bad
// end byte included) are rescanned through the same read port, each byte read and
// then parsed, with input held off for the whole rescan. A frame found during the
// rescan is sent out before the rescan goes on, and another bad end met during the
// rescan starts a fresh pass after that frame's length byte, so nested mismatches
// hold off input further. The ring holds 2**clog2(MAX_LEN+1) bytes and needs no
// clearing after reset. The output register lets a byte wait for the sink while
// the block keeps working. Configuration (flag value, timeout ticks) is to be
// written by the user only while the block is idle; the block does not enforce it.
module flag_length_frame_deframer_unit #(
	parameter int MAX_LEN = fld_pkg::MAX_LEN_DEF
) (
	input logic     clk,
	input logic     arst_n,
	fld_in_if.sink  byte_ch,
	fld_out_if.source frame_ch,
	fld_cfg_if.sink cfg_ch
);

	fld_pkg::fld_cmd_t cmd;
	fld_pkg::fld_sts_t sts;

	assign cfg_ch.ready = 1'b1;

	fld_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (byte_ch.valid),
		.in_func  (byte_ch.func),
		.in_ready (byte_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	fld_datapath #(
		.MAX_LEN (MAX_LEN)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.data_byte (byte_ch.data_byte),
		.cfg_valid (cfg_ch.valid),
		.cfg_idx   (cfg_ch.idx),
		.cfg_wdata (cfg_ch.wdata),
		.out_ready (frame_ch.ready),
		.out_valid (frame_ch.valid),
		.out_byte  (frame_ch.frame_byte),
		.out_last  (frame_ch.frame_last)
	);

endmodule
